// File: design/sipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipc_pkg: shared types and constants
// Status codes, request kinds and sequencer states for the posting-chain index.
// ----------------------------------------------------------------------------
package sipc_pkg;

   localparam int KEY_W = 31;
   localparam int REC_W = 40;
   localparam int STAT_W = 2;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_FULL     = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_WALK_RD,
      ST_WALK_OUT
   } state_type;

endpackage

// File: design/secondary_index_posting_chains.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secondary_index_posting_chains: sorted key table with record chains
// An insert runs a binary search, a sorted shift and a placement; a lookup
// runs the binary search and then walks the record chain, stepping through
// the table and node memories. One request is in flight at a time;
// results stream out one per strobe and cannot be stalled. Synchronous
// reset empties the table; memory contents are left as they are.
// ----------------------------------------------------------------------------
module secondary_index_posting_chains #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [30:0] req_group_key,
   input  logic [39:0] req_record_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [39:0] rsp_record_out,
   output logic        rsp_last
);

   // sequencer with its stores
   sipc_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_start      (start),
      .req_kind       (req_kind),
      .req_group_key  (req_group_key),
      .req_record_id  (req_record_id),
      .req_busy       (busy),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_record_out (rsp_record_out),
      .rsp_last       (rsp_last)
   );

endmodule

// File: design/sipc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipc_ctrl: index sequencer
// Binary search, sorted insert shift and chain walk, one memory step a cycle.
// ----------------------------------------------------------------------------
module sipc_ctrl #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic                      req_kind,
   input  logic [sipc_pkg::KEY_W-1:0] req_group_key,
   input  logic [sipc_pkg::REC_W-1:0] req_record_id,
   output logic                      req_busy,
   output logic                      rsp_valid,
   output logic [sipc_pkg::STAT_W-1:0] rsp_status,
   output logic [sipc_pkg::REC_W-1:0] rsp_record_out,
   output logic                      rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // storage
   logic [sipc_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [AW-1:0]              head_mem [TABLE_DEPTH];
   logic [sipc_pkg::REC_W-1:0] rec_mem [TABLE_DEPTH];
   logic [CW-1:0]              next_mem [TABLE_DEPTH];

   sipc_pkg::state_type state_ff, state_in;
   logic [CW-1:0] key_count_ff, key_count_in;
   logic [CW-1:0] node_count_ff, node_count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] walk_n_ff, walk_n_in;
   logic          hit_ff, hit_in;
   logic          kind_ff;
   logic [sipc_pkg::KEY_W-1:0] key_ff;
   logic [sipc_pkg::REC_W-1:0] rec_ff;

   // registered memory reads
   logic [sipc_pkg::KEY_W-1:0] key_rd_ff;
   logic [AW-1:0]              head_rd_ff;
   logic [sipc_pkg::REC_W-1:0] rec_rd_ff;
   logic [CW-1:0]              next_rd_ff;

   // memory control from the sequencer
   logic          tbl_rd;
   logic [AW-1:0] tbl_rd_addr;
   logic          tbl_wr;
   logic [AW-1:0] tbl_wr_addr;
   logic [sipc_pkg::KEY_W-1:0] tbl_wr_key;
   logic [AW-1:0] tbl_wr_head;
   logic          node_rd;
   logic [AW-1:0] node_rd_addr;
   logic          node_wr;
   logic [CW-1:0] node_wr_next;

   logic          out_v_ff, out_v_in;
   logic [sipc_pkg::STAT_W-1:0] out_st_ff, out_st_in;
   logic [sipc_pkg::REC_W-1:0]  out_rec_ff, out_rec_in;
   logic          out_last_ff, out_last_in;

   logic [CW-1:0] mid;
   logic          full;

   assign mid = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign full = (node_count_ff >= CW'(TABLE_DEPTH)) ||
                 (!hit_ff && key_count_ff >= CW'(TABLE_DEPTH));

   // hold memories
   always_ff @(posedge clock) begin
      if (tbl_rd) begin
         key_rd_ff  <= key_mem[tbl_rd_addr];
         head_rd_ff <= head_mem[tbl_rd_addr];
      end
      if (tbl_wr) begin
         key_mem[tbl_wr_addr]  <= tbl_wr_key;
         head_mem[tbl_wr_addr] <= tbl_wr_head;
      end
      if (node_rd) begin
         rec_rd_ff  <= rec_mem[node_rd_addr];
         next_rd_ff <= next_mem[node_rd_addr];
      end
      if (node_wr) begin
         rec_mem[node_count_ff[AW-1:0]]  <= rec_ff;
         next_mem[node_count_ff[AW-1:0]] <= node_wr_next;
      end
   end

   // capture the request and register the working values
   always_ff @(posedge clock) begin
      if (state_ff == sipc_pkg::ST_IDLE && req_start) begin
         kind_ff <= req_kind;
         key_ff  <= req_group_key;
         rec_ff  <= req_record_id;
      end
      out_rec_ff  <= out_rec_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ptr_ff      <= ptr_in;
      walk_n_ff   <= walk_n_in;
      hit_ff      <= hit_in;
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sipc_pkg::ST_IDLE;
         key_count_ff  <= '0;
         node_count_ff <= '0;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         node_count_ff <= node_count_in;
         out_v_ff      <= out_v_in;
      end
   end

   // sequence search, shift and walk
   always_comb begin
      state_in      = state_ff;
      key_count_in  = key_count_ff;
      node_count_in = node_count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ptr_in        = ptr_ff;
      walk_n_in     = walk_n_ff;
      hit_in        = hit_ff;
      out_v_in      = 1'b0;
      out_st_in     = sipc_pkg::STAT_OK;
      out_rec_in    = '0;
      out_last_in   = 1'b1;
      tbl_rd        = 1'b0;
      tbl_rd_addr   = '0;
      tbl_wr        = 1'b0;
      tbl_wr_addr   = '0;
      tbl_wr_key    = key_rd_ff;
      tbl_wr_head   = head_rd_ff;
      node_rd       = 1'b0;
      node_rd_addr  = '0;
      node_wr       = 1'b0;
      node_wr_next  = '0;
      case (state_ff)
         sipc_pkg::ST_IDLE: begin
            if (req_start) begin
               lo_in    = '0;
               hi_in    = key_count_ff;
               hit_in   = 1'b0;
               state_in = sipc_pkg::ST_SRCH_RD;
            end
         end
         sipc_pkg::ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               tbl_rd      = 1'b1;
               tbl_rd_addr = mid[AW-1:0];
               ptr_in      = mid;
               state_in    = sipc_pkg::ST_SRCH_CMP;
            end else begin
               ptr_in   = lo_ff;
               state_in = sipc_pkg::ST_DECIDE;
            end
         end
         sipc_pkg::ST_SRCH_CMP: begin
            if (key_rd_ff == key_ff) begin
               hit_in   = 1'b1;
               state_in = sipc_pkg::ST_DECIDE;
            end else begin
               if (key_rd_ff < key_ff) lo_in = CW'(ptr_ff + 1'b1);
               else hi_in = ptr_ff;
               state_in = sipc_pkg::ST_SRCH_RD;
            end
         end
         sipc_pkg::ST_DECIDE: begin
            if (kind_ff == sipc_pkg::KIND_LOOKUP) begin
               if (!hit_ff) begin
                  out_v_in  = 1'b1;
                  out_st_in = sipc_pkg::STAT_NOTFOUND;
                  state_in  = sipc_pkg::ST_IDLE;
               end else begin
                  // head_rd_ff holds the hit entry's head
                  ptr_in    = CW'(head_rd_ff);
                  walk_n_in = '0;
                  state_in  = sipc_pkg::ST_WALK_RD;
               end
            end else if (full) begin
               out_v_in  = 1'b1;
               out_st_in = sipc_pkg::STAT_FULL;
               state_in  = sipc_pkg::ST_IDLE;
            end else if (hit_ff) begin
               node_wr       = 1'b1;
               node_wr_next  = CW'(head_rd_ff);
               tbl_wr        = 1'b1;
               tbl_wr_addr   = ptr_ff[AW-1:0];
               tbl_wr_key    = key_ff;
               tbl_wr_head   = node_count_ff[AW-1:0];
               node_count_in = CW'(node_count_ff + 1'b1);
               out_v_in      = 1'b1;
               state_in      = sipc_pkg::ST_IDLE;
            end else begin
               lo_in    = key_count_ff;
               state_in = sipc_pkg::ST_SHIFT_RD;
            end
         end
         sipc_pkg::ST_SHIFT_RD: begin
            // lo_ff is the destination slot, moving down to the insert point
            if (lo_ff > ptr_ff) begin
               tbl_rd      = 1'b1;
               tbl_rd_addr = AW'(lo_ff - 1'b1);
               state_in    = sipc_pkg::ST_SHIFT_WR;
            end else begin
               state_in = sipc_pkg::ST_PLACE;
            end
         end
         sipc_pkg::ST_SHIFT_WR: begin
            tbl_wr      = 1'b1;
            tbl_wr_addr = lo_ff[AW-1:0];
            lo_in       = CW'(lo_ff - 1'b1);
            state_in    = sipc_pkg::ST_SHIFT_RD;
         end
         sipc_pkg::ST_PLACE: begin
            tbl_wr        = 1'b1;
            tbl_wr_addr   = ptr_ff[AW-1:0];
            tbl_wr_key    = key_ff;
            tbl_wr_head   = node_count_ff[AW-1:0];
            node_wr       = 1'b1;
            node_wr_next  = CW'(TABLE_DEPTH);
            node_count_in = CW'(node_count_ff + 1'b1);
            key_count_in  = CW'(key_count_ff + 1'b1);
            out_v_in      = 1'b1;
            state_in      = sipc_pkg::ST_IDLE;
         end
         sipc_pkg::ST_WALK_RD: begin
            if (ptr_ff < node_count_ff && walk_n_ff < CW'(TABLE_DEPTH)) begin
               node_rd      = 1'b1;
               node_rd_addr = ptr_ff[AW-1:0];
               state_in     = sipc_pkg::ST_WALK_OUT;
            end else begin
               // empty chain only; later ends are flagged on the last node
               out_v_in  = 1'b1;
               out_st_in = sipc_pkg::STAT_NOTFOUND;
               state_in  = sipc_pkg::ST_IDLE;
            end
         end
         sipc_pkg::ST_WALK_OUT: begin
            out_v_in    = 1'b1;
            out_rec_in  = rec_rd_ff;
            out_last_in = !(next_rd_ff < node_count_ff) ||
                          (CW'(walk_n_ff + 1'b1) >= CW'(TABLE_DEPTH));
            ptr_in      = next_rd_ff;
            walk_n_in   = CW'(walk_n_ff + 1'b1);
            state_in    = out_last_in ? sipc_pkg::ST_IDLE : sipc_pkg::ST_WALK_RD;
         end
         default: state_in = sipc_pkg::ST_IDLE;
      endcase
   end

   assign req_busy       = (state_ff != sipc_pkg::ST_IDLE);
   assign rsp_valid      = out_v_ff;
   assign rsp_status     = out_st_ff;
   assign rsp_record_out = out_rec_ff;
   assign rsp_last       = out_last_ff;

   // check counters and result framing
   a_key_le_node: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= node_count_ff) else $error("key count above node count");
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= CW'(TABLE_DEPTH)) else $error("node count overflow");
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !req_busy |-> rsp_last) else $error("final result not marked last");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sipc_pkg::STAT_OK |-> rsp_record_out == '0 && rsp_last)
      else $error("error result malformed");

endmodule

// File: tb/sipc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipc_checker: result predictor and scoreboard for the posting-chain index
// Watches request and result transfers, keeps its own copy of the key table
// and node store, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module sipc_checker #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_kind,
   input  logic [30:0] req_group_key,
   input  logic [39:0] req_record_id,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [39:0] rsp_record_out,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   localparam int END_LINK = DEPTH;

   typedef struct {
      sipc_pkg::status_type status;
      logic [39:0]          record;
      logic                 last;
   } posting_type;

   posting_type posting_q[$];
   logic [30:0] sorted_keys[DEPTH];
   int          chain_head[DEPTH];
   logic [39:0] node_rec[DEPTH];
   int          node_link[DEPTH];
   int          num_keys;
   int          num_nodes;

   initial begin
      fail_count = 0;
      num_keys = 0;
      num_nodes = 0;
   end

   assign pending = posting_q.size();

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic void push_posting(sipc_pkg::status_type st, logic [39:0] rec,
                                        logic lst);
      posting_type p;
      p.status = st;
      p.record = rec;
      p.last = lst;
      posting_q.push_back(p);
   endfunction

   // Apply one request to the shadow index and queue its results
   task automatic predict_postings(input sipc_pkg::kind_type kind,
                                   input logic [30:0] key,
                                   input logic [39:0] rec);
      int  pos;
      bit  hit;
      int  cur;
      int  n;
      int  nxt;
      hit = 0;
      pos = num_keys;
      for (int i = 0; i < num_keys; i++) begin
         if (sorted_keys[i] == key) begin
            hit = 1;
            pos = i;
            break;
         end
         if (sorted_keys[i] > key) begin
            pos = i;
            break;
         end
      end
      if (kind == sipc_pkg::KIND_INSERT) begin
         if (num_nodes >= DEPTH || (!hit && num_keys >= DEPTH)) begin
            push_posting(sipc_pkg::STAT_FULL, '0, 1'b1);
            return;
         end
         node_rec[num_nodes] = rec;
         if (hit) begin
            node_link[num_nodes] = chain_head[pos];
            chain_head[pos] = num_nodes;
         end else begin
            for (int i = num_keys; i > pos; i--) begin
               sorted_keys[i] = sorted_keys[i-1];
               chain_head[i] = chain_head[i-1];
            end
            sorted_keys[pos] = key;
            chain_head[pos] = num_nodes;
            node_link[num_nodes] = END_LINK;
            num_keys++;
         end
         num_nodes++;
         push_posting(sipc_pkg::STAT_OK, '0, 1'b1);
         return;
      end
      if (!hit) begin
         push_posting(sipc_pkg::STAT_NOTFOUND, '0, 1'b1);
         return;
      end
      // walk the chain newest first
      cur = chain_head[pos];
      n = 0;
      while (cur < num_nodes && n < DEPTH) begin
         nxt = node_link[cur];
         push_posting(sipc_pkg::STAT_OK, node_rec[cur],
                      (nxt >= num_nodes) || (n + 1 >= DEPTH));
         n++;
         cur = nxt;
      end
      if (n == 0) push_posting(sipc_pkg::STAT_NOTFOUND, '0, 1'b1);
   endtask

   // Predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      posting_type p;
      if (!reset) begin
         if (rsp_valid) begin
            if (posting_q.size() == 0) begin
               report($sformatf("unexpected result status=%0d rec=%0h last=%0b",
                                rsp_status, rsp_record_out, rsp_last));
            end else begin
               p = posting_q.pop_front();
               if (rsp_status !== p.status)
                  report($sformatf("status got %0d want %0d", rsp_status, p.status));
               if (rsp_record_out !== p.record)
                  report($sformatf("record got %0h want %0h", rsp_record_out, p.record));
               if (rsp_last !== p.last)
                  report($sformatf("last got %0b want %0b", rsp_last, p.last));
            end
         end
         if (start && !busy)
            predict_postings(sipc_pkg::kind_type'(req_kind), req_group_key,
                             req_record_id);
      end
   end

endmodule

// File: tb/tb_secondary_index_posting_chains.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_secondary_index_posting_chains: stimulus and verdict for the index
// Drives directed and random insert and lookup requests with random gaps,
// lets the checker score the results, and stops on a stall watchdog.
// ----------------------------------------------------------------------------
module tb_secondary_index_posting_chains;

   localparam int STALL_LIMIT = 3000;
   localparam int KEY_POOL = 24;
   localparam logic [39:0] REC_TOP = 40'd999999999999;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [30:0] req_group_key;
   logic [39:0] req_record_id;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [39:0] rsp_record_out;
   logic        rsp_last;
   int          fail_count;
   int          pending;
   int          stall_cycles;
   bit          no_gaps;
   logic [30:0] key_pool[KEY_POOL];

   secondary_index_posting_chains dut (.*);

   sipc_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic [39:0] rand_record();
      logic [39:0] r;
      r = 40'({$urandom, $urandom});
      if (r > REC_TOP) r = r - REC_TOP;
      return r;
   endfunction

   // Hold off, then present one request until it transfers
   task automatic send_request(input sipc_pkg::kind_type kind, input logic [30:0] key,
                               input logic [39:0] rec);
      int r;
      int gap;
      r = $urandom_range(0, 19);
      gap = 0;
      if (!no_gaps) begin
         if (r >= 10 && r < 18) gap = $urandom_range(1, 4);
         else if (r >= 18) gap = $urandom_range(15, 60);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_group_key <= key;
      req_record_id <= rec;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int r;
      logic [30:0] key;
      reset = 1'b1;
      start = 1'b0;
      req_kind = sipc_pkg::KIND_INSERT;
      req_group_key = '0;
      req_record_id = '0;
      stall_cycles = 0;
      no_gaps = 0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 31'($urandom);
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: miss on empty table, key and record extremes, chain order
      send_request(sipc_pkg::KIND_LOOKUP, '0, '0);
      send_request(sipc_pkg::KIND_INSERT, '0, '0);
      send_request(sipc_pkg::KIND_INSERT, '1, REC_TOP);
      send_request(sipc_pkg::KIND_INSERT, '0, REC_TOP);
      send_request(sipc_pkg::KIND_INSERT, '0, 40'h5555555555 & REC_TOP);
      send_request(sipc_pkg::KIND_INSERT, 31'h40000000, 40'h2AAAAAAAAA);
      send_request(sipc_pkg::KIND_LOOKUP, '0, '1);
      send_request(sipc_pkg::KIND_LOOKUP, '1, '0);
      send_request(sipc_pkg::KIND_LOOKUP, 31'h40000000, '0);
      send_request(sipc_pkg::KIND_LOOKUP, 31'h3FFFFFFF, '0);
      send_request(sipc_pkg::KIND_LOOKUP, 31'h7FFFFFFE, '0);
      send_request(sipc_pkg::KIND_INSERT, 31'h00000001, 40'd1);
      send_request(sipc_pkg::KIND_LOOKUP, 31'h00000001, '0);

      // random: pooled keys so lookups hit; store fills and then reports full
      for (int n = 0; n < 270; n++) begin
         if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 9);
         key = (r == 0) ? 31'($urandom) : key_pool[$urandom_range(0, KEY_POOL - 1)];
         if ($urandom_range(0, 9) < 5)
            send_request(sipc_pkg::KIND_INSERT, key, rand_record());
         else
            send_request(sipc_pkg::KIND_LOOKUP, key, 40'($urandom));
      end
      start <= 1'b0;

      // drain outstanding results, then watch for strays
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
